/* src/ttq_pkg.sv */
package ttq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int TIME_W      = 32;
    localparam int NUMER_W     = 24;
    localparam int FRAC_W      = 8;
    localparam int SPEED_W     = 32;
    localparam int CMD_W       = 3;

    localparam logic [NUMER_W-1:0] NUMER_RESET = NUMER_W'(3200000);

    localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIRST  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SECOND = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TAKE   = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TIME_W-1:0] timestamp;
    } ttq_in_t;

    typedef struct packed {
        logic               record_valid;
        logic [TIME_W-1:0]  first_time;
        logic [TIME_W-1:0]  second_time;
        logic [SPEED_W-1:0] speed_q24_8;
    } ttq_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_EMIT
    } ttq_state_t;

endpackage

/* src/two_sensor_transit_time_queue.sv */
// Pairs first- and second-sensor timer captures into a ring of QUEUE_DEPTH entries
// (QUEUE_DEPTH - 1 usable) and reports each popped pair with its speed in unsigned
// Q24.8, floor(speed_numerator * 256 / (second - first)). A take on an empty ring goes
// straight to the emit state; a take that pops a record does one ring read and then
// runs the radix-2 divider, one quotient bit per cycle. One word is handled at a time;
// a finished result waits in the output register while the next word is accepted.
// speed_numerator must be written by the user through cfg_wr_en/cfg_wr_data only while
// the block is idle; the block itself does not enforce it.
module two_sensor_transit_time_queue
    import ttq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ttq_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ttq_out_t           m_data,
    input  logic               cfg_wr_en,
    input  logic [NUMER_W-1:0] cfg_wr_data
);

    localparam int RAM_W = 2 * TIME_W;

    ttq_state_t         state_reg, state_next;
    logic               acq_reg, acq_next;
    logic               armed_reg, armed_next;
    logic [TIME_W-1:0]  armed_time_reg, armed_time_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NUMER_W-1:0] numer_reg;
    logic [TIME_W-1:0]  first_reg, first_next;
    logic [TIME_W-1:0]  second_reg, second_next;
    logic               rec_valid_reg, rec_valid_next;
    logic               m_valid_reg, m_valid_next;
    ttq_out_t           m_data_reg, m_data_next;

    logic               ram_we;
    logic [RAM_W-1:0]   ram_wdata;
    logic [RAM_W-1:0]   ram_rdata;
    logic               div_start;
    logic               div_done;
    logic [SPEED_W-1:0] div_quot;
    logic [TIME_W-1:0]  div_divisor;
    logic [PTR_W-1:0]   wr_ptr_inc;
    logic [PTR_W-1:0]   rd_ptr_inc;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign wr_ptr_inc  = ptr_inc(wr_ptr_reg);
    assign rd_ptr_inc  = ptr_inc(rd_ptr_reg);
    assign ram_wdata   = {armed_time_reg, s_data.timestamp};
    assign div_divisor = ram_rdata[TIME_W-1:0] - ram_rdata[RAM_W-1:TIME_W];

    ttq_ram #(
        .WIDTH(RAM_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ring (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(wr_ptr_reg),
        .wdata(ram_wdata),
        .raddr(rd_ptr_reg),
        .rdata(ram_rdata)
    );

    ttq_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend({numer_reg, FRAC_W'(0)}),
        .divisor (div_divisor),
        .done    (div_done),
        .quotient(div_quot)
    );

    always_comb begin
        state_next      = state_reg;
        acq_next        = acq_reg;
        armed_next      = armed_reg;
        armed_time_next = armed_time_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        rec_valid_next  = rec_valid_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        div_start       = 1'b0;
        s_ready         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_data.command)
                        CMD_START, CMD_STOP: begin
                            acq_next    = (s_data.command == CMD_START);
                            armed_next  = 1'b0;
                            wr_ptr_next = '0;
                            rd_ptr_next = '0;
                        end
                        CMD_FIRST: begin
                            if (acq_reg) begin
                                armed_time_next = s_data.timestamp;
                                armed_next      = 1'b1;
                            end
                        end
                        CMD_SECOND: begin
                            if (acq_reg && armed_reg) begin
                                armed_next = 1'b0;
                                if (s_data.timestamp != armed_time_reg &&
                                    wr_ptr_inc != rd_ptr_reg) begin
                                    ram_we      = 1'b1;
                                    wr_ptr_next = wr_ptr_inc;
                                end
                            end
                        end
                        CMD_TAKE: begin
                            // The ring is read at rd_ptr_reg on this edge.
                            if (rd_ptr_reg == wr_ptr_reg) begin
                                rec_valid_next = 1'b0;
                                state_next     = ST_EMIT;
                            end else begin
                                rd_ptr_next = rd_ptr_inc;
                                state_next  = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                first_next     = ram_rdata[RAM_W-1:TIME_W];
                second_next    = ram_rdata[TIME_W-1:0];
                rec_valid_next = 1'b1;
                div_start      = 1'b1;
                state_next     = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (rec_valid_reg) begin
                        m_data_next.record_valid = 1'b1;
                        m_data_next.first_time   = first_reg;
                        m_data_next.second_time  = second_reg;
                        m_data_next.speed_q24_8  = div_quot;
                    end else begin
                        m_data_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            acq_reg        <= 1'b0;
            armed_reg      <= 1'b0;
            armed_time_reg <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            numer_reg      <= NUMER_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            acq_reg        <= acq_next;
            armed_reg      <= armed_next;
            armed_time_reg <= armed_time_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                numer_reg <= cfg_wr_data;
            end
        end
        first_reg     <= first_next;
        second_reg    <= second_next;
        rec_valid_reg <= rec_valid_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ptr_reg <= PTR_W'(QUEUE_DEPTH - 1) && rd_ptr_reg <= PTR_W'(QUEUE_DEPTH - 1))
        else $error("ring pointer beyond the ring");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> wr_ptr_inc != rd_ptr_reg)
        else $error("ring written while full");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider result outside the divide phase");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.record_valid |->
            m_data_reg.first_time == '0 && m_data_reg.second_time == '0 &&
            m_data_reg.speed_q24_8 == '0)
        else $error("empty-ring word carries nonzero fields");

    a_pop_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> $past(rd_ptr_reg) != $past(wr_ptr_reg))
        else $error("ring read while empty");

endmodule

/* src/ttq_ram.sv */
module ttq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/ttq_div.sv */
module ttq_div
    import ttq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [SPEED_W-1:0] dividend,
    input  logic [TIME_W-1:0]  divisor,
    output logic               done,
    output logic [SPEED_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SPEED_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SPEED_W-1:0] quo_reg, quo_next;
    logic [TIME_W-1:0]  rem_reg, rem_next;
    logic [TIME_W-1:0]  dvs_reg, dvs_next;
    logic               zero_reg, zero_next;
    logic [TIME_W:0]    rem_shift;
    logic [TIME_W:0]    rem_diff;

    // One quotient bit per cycle, restoring form.
    assign rem_shift = {rem_reg, quo_reg[SPEED_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        zero_next = zero_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SPEED_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            zero_next = (divisor == '0);
        end else if (busy_reg) begin
            if (!rem_diff[TIME_W]) begin
                rem_next = rem_diff[TIME_W-1:0];
                quo_next = {quo_reg[SPEED_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[TIME_W-1:0];
                quo_next = {quo_reg[SPEED_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        zero_reg <= zero_next;
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : quo_reg;

    a_done_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider finished without running");

endmodule
